@@ rtl/ubx_nav_poll_and_frame_receiver_macros.svh @@
// Assertion macros for the UBX NAV receiver checker
`ifndef UBX_NAV_POLL_AND_FRAME_RECEIVER_MACROS_SVH
`define UBX_NAV_POLL_AND_FRAME_RECEIVER_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define UBX_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define UBX_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ rtl/ubx_pkg.sv @@
// Package: payload types, constants and state codes for the UBX NAV receiver
package ubx_pkg;
  localparam logic [1:0] OP_RX_BYTE = 2'd0;
  localparam logic [1:0] OP_TICK    = 2'd1;
  localparam logic [1:0] OP_STORED  = 2'd2;

  localparam logic [2:0] REG_DLY_RX   = 3'd0;
  localparam logic [2:0] REG_DLY_TX   = 3'd1;
  localparam logic [2:0] REG_GOOD_LIM = 3'd2;
  localparam logic [2:0] REG_ALL_EN   = 3'd3;
  localparam logic [2:0] REG_ALL_LIM  = 3'd4;

  localparam logic [7:0] SYNC1    = 8'hB5;
  localparam logic [7:0] SYNC2    = 8'h62;
  localparam logic [7:0] CLS_NAV  = 8'h01;
  localparam logic [7:0] ID_POSLLH = 8'h02;
  localparam logic [7:0] ID_TIMEGPS = 8'h20;
  localparam logic [7:0] ID_TIMEUTC = 8'h21;
  localparam logic [6:0] LEN_POSLLH = 7'd36;
  localparam logic [6:0] LEN_TIMEGPS = 7'd24;
  localparam logic [6:0] LEN_TIMEUTC = 7'd28;
  localparam logic [6:0] LEN_POLL = 7'd8;
  localparam logic [2:0] VALID_MASK = 3'h7;
  localparam logic [2:0] VALID_MIN  = 3'h3;
  localparam logic [15:0] YEAR_RST = 16'd1987;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CK_RD, ST_CK_ACC, ST_EVAL, ST_EMIT_RX, ST_EMIT_POLL
  } state_e;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [5:0]  byte_index;
    logic        last;
    logic [6:0]  frame_length;
    logic [7:0]  message_id;
    logic [15:0] year;
    logic [7:0]  month;
    logic [7:0]  day;
    logic [7:0]  hour;
    logic [7:0]  minute;
    logic [7:0]  second;
  } out_t;
endpackage

@@ rtl/ubx_fletcher.sv @@
// Fletcher checksum accumulator shared by poll build and frame check
module ubx_fletcher (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       clear_i,
  input  logic       add_i,
  input  logic [7:0] byte_i,
  output logic [7:0] ck_a_o,
  output logic [7:0] ck_b_o
);
  logic [7:0] a_q, a_d, b_q, b_d;

  always_comb begin
    a_d = a_q;
    b_d = b_q;
    if (clear_i) begin
      a_d = '0;
      b_d = '0;
    end else if (add_i) begin
      a_d = a_q + byte_i;
      b_d = b_q + a_q + byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0;
      b_q <= '0;
    end else begin
      a_q <= a_d;
      b_q <= b_d;
    end
  end

  assign ck_a_o = a_q;
  assign ck_b_o = b_q;
endmodule

@@ rtl/ubx_nav_poll_and_frame_receiver.sv @@
// Top level: UBX NAV poll generator and reply frame receiver
//  channel | direction | handshake             | payload
//  in      | input     | in_valid_i/in_stall_o | ubx_pkg::in_t
//  out     | output    | out_valid_o/out_stall_i | ubx_pkg::out_t
//  cfg     | input     | cfg_we_i              | cfg_idx_i, cfg_data_i
// A poll emits 8 bytes, one per cycle unless output stalls, its checksum folding in as
// bytes 1..4 go out. POSLLH and TIMEGPS frames emit 36 or 24 bytes at that rate; TIMEUTC
// first reads bytes 2..27 back via its read and accumulate states, evaluates, then emits
// 28. Reset clears control state, not the frame memory. Output stall holds the current
// result; input stays stalled until the last one transfers.
module ubx_nav_poll_and_frame_receiver #(
  parameter int RX_DEPTH = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  ubx_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output ubx_pkg::out_t out_data_o,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [15:0]   cfg_data_i
);
  localparam int AW = $clog2(RX_DEPTH);
  localparam int CW = $clog2(RX_DEPTH + 1);

  ubx_pkg::state_e st_q, st_d;

  logic [15:0] dly_rx_q, dly_tx_q;
  logic [7:0]  good_lim_q, all_lim_q;
  logic        all_en_q;

  logic [7:0] mem [RX_DEPTH];
  logic [7:0] rdata_q;
  logic [AW-1:0] raddr;
  logic       mem_we;
  logic [AW-1:0] waddr;

  logic [CW-1:0] cnt_q, cnt_d;
  logic recv_q, recv_d, pend_q, pend_d, await_q, await_d, pos_q, pos_d;
  logic [15:0] now_q, now_d, tx_ms_q, tx_ms_d, rx_ms_q, rx_ms_d;
  logic [7:0] good_q, good_d, all_q, all_d;
  logic [15:0] year_q, year_d;
  logic [7:0] mon_q, mon_d, day_q, day_d, hr_q, hr_d, min_q, min_d, sec_q, sec_d;
  logic [7:0] id_q, id_d;
  logic [7:0] rxid_q, rxid_d;
  logic [63:0] tbuf_q, tbuf_d;
  logic [6:0] len_q, len_d;
  logic [5:0] idx_q, idx_d;

  logic ck_clr, ck_add;
  logic [7:0] ck_byte, ck_a, ck_b;
  logic [7:0] ckr_a_q, ckr_a_d;
  logic ck_ok;

  logic accept;
  ubx_pkg::out_t o_q, o_d;
  logic ov_q, ov_d;
  logic [7:0] poll_id;
  logic [7:0] poll_byte;
  logic [15:0] since_rx, since_tx;
  logic [CW-1:0] cnt_inc;
  logic hdr_bad, done_frame;
  logic [6:0] flen;
  logic [7:0] id_cur;

  ubx_fletcher u_ck (
    .clk_i(clk_i), .rst_ni(rst_ni), .clear_i(ck_clr), .add_i(ck_add),
    .byte_i(ck_byte), .ck_a_o(ck_a), .ck_b_o(ck_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dly_rx_q <= 16'd500;
      dly_tx_q <= 16'd700;
      good_lim_q <= 8'd5;
      all_en_q <= 1'b0;
      all_lim_q <= 8'd100;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ubx_pkg::REG_DLY_RX:   dly_rx_q <= cfg_data_i;
        ubx_pkg::REG_DLY_TX:   dly_tx_q <= cfg_data_i;
        ubx_pkg::REG_GOOD_LIM: good_lim_q <= cfg_data_i[7:0];
        ubx_pkg::REG_ALL_EN:   all_en_q <= cfg_data_i[0];
        ubx_pkg::REG_ALL_LIM:  all_lim_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[waddr] <= in_data_i.rx_byte;
    rdata_q <= mem[raddr];
  end

  assign in_stall_o = (st_q != ubx_pkg::ST_IDLE) || ov_q;
  assign accept = in_valid_i && !in_stall_o;
  assign poll_id = pos_q ? ubx_pkg::ID_POSLLH : ubx_pkg::ID_TIMEUTC;
  assign cnt_inc = cnt_q + CW'(1);
  assign waddr = cnt_q[AW-1:0];
  assign id_cur = (cnt_q == CW'(3)) ? in_data_i.rx_byte : rxid_q;
  assign since_rx = now_q + 16'd1 - rx_ms_q;
  assign since_tx = now_q + 16'd1 - tx_ms_q;
  // received checksum: CK_A held from byte 26, CK_B still on the read port
  assign ck_ok = (ckr_a_q == ck_a) && (rdata_q == ck_b);

  always_comb begin
    hdr_bad = 1'b0;
    if (cnt_q == CW'(1) && in_data_i.rx_byte != ubx_pkg::SYNC2) hdr_bad = 1'b1;
    if (cnt_q == CW'(2) && in_data_i.rx_byte != ubx_pkg::CLS_NAV) hdr_bad = 1'b1;
    if (cnt_q == CW'(3) && in_data_i.rx_byte != ubx_pkg::ID_POSLLH &&
        in_data_i.rx_byte != ubx_pkg::ID_TIMEGPS &&
        in_data_i.rx_byte != ubx_pkg::ID_TIMEUTC) hdr_bad = 1'b1;
    flen = '0;
    if (cnt_q >= CW'(3)) begin
      if (cnt_inc == CW'(ubx_pkg::LEN_POSLLH) && id_cur == ubx_pkg::ID_POSLLH)
        flen = ubx_pkg::LEN_POSLLH;
      if (cnt_inc == CW'(ubx_pkg::LEN_TIMEGPS) && id_cur == ubx_pkg::ID_TIMEGPS)
        flen = ubx_pkg::LEN_TIMEGPS;
      if (cnt_inc == CW'(ubx_pkg::LEN_TIMEUTC) && id_cur == ubx_pkg::ID_TIMEUTC)
        flen = ubx_pkg::LEN_TIMEUTC;
    end
    done_frame = flen != '0;
  end

  always_comb begin
    case (idx_q[2:0])
      3'd0: poll_byte = ubx_pkg::SYNC1;
      3'd1: poll_byte = ubx_pkg::SYNC2;
      3'd2: poll_byte = ubx_pkg::CLS_NAV;
      3'd3: poll_byte = id_q;
      3'd4: poll_byte = 8'h00;
      3'd5: poll_byte = 8'h00;
      3'd6: poll_byte = ck_a;
      default: poll_byte = ck_b;
    endcase
  end

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      ubx_pkg::ST_IDLE: begin
        if (accept && in_data_i.opcode == ubx_pkg::OP_RX_BYTE &&
            done_frame && (recv_q || (in_data_i.rx_byte == ubx_pkg::SYNC1 &&
            !pend_q && await_q)))
          st_d = (id_cur == ubx_pkg::ID_TIMEUTC) ? ubx_pkg::ST_CK_RD
                                                  : ubx_pkg::ST_EMIT_RX;
        else if (accept && in_data_i.opcode == ubx_pkg::OP_TICK &&
                 since_rx >= dly_rx_q && since_tx >= dly_tx_q)
          st_d = ubx_pkg::ST_EMIT_POLL;
      end
      ubx_pkg::ST_CK_RD:  st_d = ubx_pkg::ST_CK_ACC;
      ubx_pkg::ST_CK_ACC: st_d = (idx_q == 6'd27) ? ubx_pkg::ST_EVAL : ubx_pkg::ST_CK_RD;
      ubx_pkg::ST_EVAL:   st_d = ubx_pkg::ST_EMIT_RX;
      ubx_pkg::ST_EMIT_RX, ubx_pkg::ST_EMIT_POLL:
        if (!(ov_q && out_stall_i) && idx_q == 6'(len_q - 7'd1) &&
            (ov_q ? 1'b1 : 1'b0) && !out_stall_i)
          st_d = ubx_pkg::ST_IDLE;
      default: st_d = ubx_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cnt_d = cnt_q; recv_d = recv_q; pend_d = pend_q; await_d = await_q; pos_d = pos_q;
    now_d = now_q; tx_ms_d = tx_ms_q; rx_ms_d = rx_ms_q; good_d = good_q; all_d = all_q;
    year_d = year_q; mon_d = mon_q; day_d = day_q; hr_d = hr_q; min_d = min_q;
    sec_d = sec_q; id_d = id_q; len_d = len_q; idx_d = idx_q; ckr_a_d = ckr_a_q;
    rxid_d = rxid_q; tbuf_d = tbuf_q;
    mem_we = 1'b0; raddr = AW'(idx_q);
    ck_clr = 1'b0; ck_add = 1'b0; ck_byte = rdata_q;
    o_d = o_q; ov_d = ov_q && out_stall_i;
    case (st_q)
      ubx_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_data_i.opcode)
            ubx_pkg::OP_RX_BYTE: begin
              if (recv_q || (in_data_i.rx_byte == ubx_pkg::SYNC1 && !pend_q && await_q)) begin
                mem_we = 1'b1;
                if (cnt_q == CW'(3)) rxid_d = in_data_i.rx_byte;
                cnt_d = cnt_inc;
                recv_d = 1'b1;
                if (!recv_q) begin
                  cnt_d = CW'(1);
                  mem_we = 1'b1;
                end
                if (done_frame) begin
                  rx_ms_d = now_q;
                  pend_d = 1'b1;
                  len_d = flen;
                  id_d = id_cur;
                  idx_d = 6'd2;
                  ck_clr = 1'b1;
                  raddr = '0;
                  if (id_cur != ubx_pkg::ID_TIMEUTC) idx_d = 6'd0;
                end
                if (hdr_bad || done_frame || cnt_inc >= CW'(RX_DEPTH)) begin
                  cnt_d = '0; recv_d = 1'b0; await_d = 1'b0;
                end
              end
            end
            ubx_pkg::OP_TICK: begin
              now_d = now_q + 16'd1;
              if (since_rx >= dly_rx_q && since_tx >= dly_tx_q) begin
                tx_ms_d = now_d; await_d = 1'b1;
                id_d = poll_id; len_d = ubx_pkg::LEN_POLL; idx_d = 6'd0;
                ck_clr = 1'b1;
              end
            end
            ubx_pkg::OP_STORED: pend_d = 1'b0;
            default: ;
          endcase
        end
      end
      ubx_pkg::ST_CK_RD: ;
      ubx_pkg::ST_CK_ACC: begin
        if (idx_q <= 6'd25) ck_add = 1'b1;
        if (idx_q == 6'd26) ckr_a_d = rdata_q;
        // collect date bytes 18..24 and the validity byte 25
        if (idx_q >= 6'd18 && idx_q <= 6'd25) tbuf_d = {rdata_q, tbuf_q[63:8]};
        idx_d = idx_q + 6'd1;
      end
      ubx_pkg::ST_EVAL: begin
        if (ck_ok) begin
          if ((tbuf_q[58:56] & ubx_pkg::VALID_MASK) >= ubx_pkg::VALID_MIN) begin
            year_d = tbuf_q[15:0];
            mon_d = tbuf_q[23:16]; day_d = tbuf_q[31:24]; hr_d = tbuf_q[39:32];
            min_d = tbuf_q[47:40]; sec_d = tbuf_q[55:48];
            if (good_q != 8'hFF) good_d = good_q + 8'd1;
          end else begin
            good_d = '0;
          end
          if (all_en_q && all_q != 8'hFF) all_d = all_q + 8'd1;
          if (good_d >= good_lim_q || (all_en_q && all_d >= all_lim_q)) pos_d = 1'b1;
        end
      end
      default: ;
    endcase
    if (st_q == ubx_pkg::ST_EVAL) idx_d = 6'd0;
    if (st_q == ubx_pkg::ST_EMIT_RX || st_q == ubx_pkg::ST_EMIT_POLL) begin
      if (!ov_q || !out_stall_i) begin
        ov_d = 1'b1;
        o_d.kind = (st_q == ubx_pkg::ST_EMIT_RX);
        o_d.data_byte = (st_q == ubx_pkg::ST_EMIT_RX) ? rdata_q : poll_byte;
        o_d.byte_index = idx_q;
        o_d.last = idx_q == 6'(len_q - 7'd1);
        o_d.frame_length = len_q;
        o_d.message_id = id_q;
        o_d.year = year_q; o_d.month = mon_q; o_d.day = day_q;
        o_d.hour = hr_q; o_d.minute = min_q; o_d.second = sec_q;
        idx_d = idx_q + 6'd1;
        raddr = AW'(idx_q + 6'd1);
        if (st_q == ubx_pkg::ST_EMIT_POLL && (idx_q >= 6'd1 && idx_q <= 6'd4)) begin
          ck_add = 1'b1;
          ck_byte = (idx_q == 6'd2) ? id_q : ((idx_q == 6'd1) ? ubx_pkg::CLS_NAV : 8'h00);
        end
      end
    end
    if (st_q == ubx_pkg::ST_EVAL) raddr = '0;
  end

  assign out_valid_o = ov_q;
  assign out_data_o = o_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ubx_pkg::ST_IDLE; cnt_q <= '0; recv_q <= 1'b0; pend_q <= 1'b0;
      await_q <= 1'b0; pos_q <= 1'b0; now_q <= '0; tx_ms_q <= '0; rx_ms_q <= '0;
      good_q <= '0; all_q <= '0; year_q <= ubx_pkg::YEAR_RST; mon_q <= 8'd11;
      day_q <= 8'd6; hr_q <= 8'd8; min_q <= '0; sec_q <= '0; ov_q <= 1'b0;
      id_q <= '0; len_q <= '0; idx_q <= '0; ckr_a_q <= '0;
      rxid_q <= '0; tbuf_q <= '0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; recv_q <= recv_d; pend_q <= pend_d;
      await_q <= await_d; pos_q <= pos_d; now_q <= now_d; tx_ms_q <= tx_ms_d;
      rx_ms_q <= rx_ms_d; good_q <= good_d; all_q <= all_d; year_q <= year_d;
      mon_q <= mon_d; day_q <= day_d; hr_q <= hr_d; min_q <= min_d; sec_q <= sec_d;
      ov_q <= ov_d; id_q <= id_d; len_q <= len_d; idx_q <= idx_d; ckr_a_q <= ckr_a_d;
      rxid_q <= rxid_d; tbuf_q <= tbuf_d;
    end
  end

  always_ff @(posedge clk_i) o_q <= o_d;
endmodule

@@ rtl/ubx_checker.sv @@
// Port checker for the UBX NAV receiver, bound to the top level
`include "ubx_nav_poll_and_frame_receiver_macros.svh"
module ubx_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input ubx_pkg::out_t out_data_o
);
  `UBX_ASSERT_NXT(a_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))
  `UBX_ASSERT_IMP(a_idx, clk_i, rst_ni, out_valid_o, out_data_o.byte_index < 6'(out_data_o.frame_length))
  `UBX_ASSERT_IMP(a_busy, clk_i, rst_ni, out_valid_o && !out_data_o.last, in_stall_o)
endmodule

bind ubx_nav_poll_and_frame_receiver ubx_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_stall_o(in_stall_o),
  .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
);

@@ test/ubx_nav_poll_and_frame_receiver_tb.sv @@
// Testbench for the UBX NAV poll generator and reply frame receiver
`timescale 1ns / 100ps

module testbench;
  localparam logic KIND_POLL  = 1'b0;
  localparam logic KIND_STORE = 1'b1;
  localparam logic [1:0] OP_UNKNOWN = 2'd3;
  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 150;

  class nav_scoreboard;
    ubx_pkg::out_t expected_q[$];
    logic [7:0] rx_mem[64];
    int unsigned rx_count;
    bit receiving, store_pending, reply_awaited, position_mode;
    logic [15:0] now_ms, sent_ms, rcvd_ms;
    logic [7:0] good_cnt, all_cnt;
    logic [15:0] year;
    logic [7:0] month, day, hour, minute, second;
    logic [15:0] dly_rx, dly_tx;
    logic [7:0] good_lim, all_lim;
    bit all_en;
    int errors, checked, polls, frames;

    function new();
      rx_count = 0; receiving = 0; store_pending = 0; reply_awaited = 0;
      position_mode = 0; now_ms = 0; sent_ms = 0; rcvd_ms = 0;
      good_cnt = 0; all_cnt = 0;
      year = ubx_pkg::YEAR_RST; month = 11; day = 6; hour = 8; minute = 0; second = 0;
      dly_rx = 500; dly_tx = 700; good_lim = 5; all_en = 0; all_lim = 100;
      errors = 0; checked = 0; polls = 0; frames = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] v);
      case (idx)
        ubx_pkg::REG_DLY_RX:   dly_rx = v;
        ubx_pkg::REG_DLY_TX:   dly_tx = v;
        ubx_pkg::REG_GOOD_LIM: good_lim = v[7:0];
        ubx_pkg::REG_ALL_EN:   all_en = v[0];
        ubx_pkg::REG_ALL_LIM:  all_lim = v[7:0];
        default: ;
      endcase
    endfunction

    static function logic [15:0] fletcher(logic [7:0] b[$]);
      logic [7:0] a, c;
      a = 0; c = 0;
      foreach (b[i]) begin
        a = a + b[i];
        c = c + a;
      end
      return {a, c};
    endfunction

    function void push(logic kind, logic [7:0] d, int idx, logic lst, logic [6:0] len,
                       logic [7:0] id);
      ubx_pkg::out_t o;
      o.kind = kind; o.data_byte = d; o.byte_index = idx[5:0]; o.last = lst;
      o.frame_length = len; o.message_id = id; o.year = year; o.month = month;
      o.day = day; o.hour = hour; o.minute = minute; o.second = second;
      expected_q.push_back(o);
    endfunction

    function void update_time();
      logic [7:0] body[$];
      logic [15:0] ck;
      if (rx_mem[3] != ubx_pkg::ID_TIMEUTC) return;
      for (int i = 2; i < 26; i++) body.push_back(rx_mem[i]);
      ck = fletcher(body);
      if (rx_mem[26] != ck[15:8] || rx_mem[27] != ck[7:0]) return;
      if ((rx_mem[25][2:0] & ubx_pkg::VALID_MASK) >= ubx_pkg::VALID_MIN) begin
        year = {rx_mem[19], rx_mem[18]};
        month = rx_mem[20]; day = rx_mem[21]; hour = rx_mem[22];
        minute = rx_mem[23]; second = rx_mem[24];
        if (good_cnt < 255) good_cnt++;
      end else begin
        good_cnt = 0;
      end
      if (all_en && all_cnt < 255) all_cnt++;
      if (good_cnt >= good_lim || (all_en && all_cnt >= all_lim)) position_mode = 1;
    endfunction

    function void note_input(ubx_pkg::in_t it);
      logic [7:0] b, id;
      logic [6:0] len;
      logic [7:0] f[$];
      logic [15:0] ck;
      bit done;
      b = it.rx_byte;
      done = 0;
      len = 0;
      case (it.opcode)
        ubx_pkg::OP_RX_BYTE: begin
          if (!receiving && b == ubx_pkg::SYNC1 && !store_pending && reply_awaited) begin
            receiving = 1;
            rx_count = 0;
          end
          if (receiving) begin
            if (rx_count == 1 && b != ubx_pkg::SYNC2) done = 1;
            if (rx_count == 2 && b != ubx_pkg::CLS_NAV) done = 1;
            if (rx_count == 3 && b != ubx_pkg::ID_POSLLH && b != ubx_pkg::ID_TIMEGPS &&
                b != ubx_pkg::ID_TIMEUTC)
              done = 1;
            if (rx_count < 64) rx_mem[rx_count] = b;
            rx_count++;
            id = rx_mem[3];
            if (rx_count >= 4) begin
              if (rx_count == ubx_pkg::LEN_POSLLH && id == ubx_pkg::ID_POSLLH)
                len = ubx_pkg::LEN_POSLLH;
              if (rx_count == ubx_pkg::LEN_TIMEGPS && id == ubx_pkg::ID_TIMEGPS)
                len = ubx_pkg::LEN_TIMEGPS;
              if (rx_count == ubx_pkg::LEN_TIMEUTC && id == ubx_pkg::ID_TIMEUTC)
                len = ubx_pkg::LEN_TIMEUTC;
            end
            if (len != 0) begin
              rcvd_ms = now_ms;
              update_time();
              store_pending = 1;
              done = 1;
              frames++;
              for (int i = 0; i < len; i++)
                push(KIND_STORE, rx_mem[i], i, i + 1 == len, len, id);
            end
            if (rx_count >= 64) done = 1;
          end
          if (done) begin
            rx_count = 0;
            receiving = 0;
            reply_awaited = 0;
          end
        end
        ubx_pkg::OP_TICK: begin
          now_ms = now_ms + 1;
          if (16'(now_ms - rcvd_ms) >= dly_rx && 16'(now_ms - sent_ms) >= dly_tx) begin
            id = position_mode ? ubx_pkg::ID_POSLLH : ubx_pkg::ID_TIMEUTC;
            f = '{ubx_pkg::SYNC1, ubx_pkg::SYNC2, ubx_pkg::CLS_NAV, id, 8'h00, 8'h00};
            ck = fletcher(f[2:5]);
            f.push_back(ck[15:8]);
            f.push_back(ck[7:0]);
            sent_ms = now_ms;
            reply_awaited = 1;
            polls++;
            for (int i = 0; i < 8; i++)
              push(KIND_POLL, f[i], i, i == 7, ubx_pkg::LEN_POLL, id);
          end
        end
        ubx_pkg::OP_STORED: store_pending = 0;
        default: ;
      endcase
    endfunction

    function bit field_ok(string nm, logic [15:0] e, logic [15:0] a);
      if (e !== a)
        $display("%0t: mismatch in %s: expected %h, actual %h", $realtime, nm, e, a);
      return e === a;
    endfunction

    function void check_result(ubx_pkg::out_t got);
      ubx_pkg::out_t e;
      bit ok;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h", $realtime, got);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      checked++;
      ok = field_ok("kind", e.kind, got.kind);
      ok &= field_ok("data_byte", e.data_byte, got.data_byte);
      ok &= field_ok("byte_index", e.byte_index, got.byte_index);
      ok &= field_ok("last", e.last, got.last);
      ok &= field_ok("frame_length", e.frame_length, got.frame_length);
      ok &= field_ok("message_id", e.message_id, got.message_id);
      ok &= field_ok("year", e.year, got.year);
      ok &= field_ok("month", e.month, got.month);
      ok &= field_ok("day", e.day, got.day);
      ok &= field_ok("hour", e.hour, got.hour);
      ok &= field_ok("minute", e.minute, got.minute);
      ok &= field_ok("second", e.second, got.second);
      if (!ok) errors++;
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  ubx_pkg::in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  ubx_pkg::out_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;

  nav_scoreboard sb = new();
  int items_sent = 0;
  int idle_cycles = 0;
  bit hold_req = 0;

  ubx_nav_poll_and_frame_receiver dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function int gap_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 10) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("%0t: timeout, nothing transferred for %0d cycles", $realtime, IDLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver stall: random, with one long hold on request
  initial begin
    int g;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 0;
        out_stall_i <= 1'b0;
      end else begin
        g = gap_len();
        if (g > 0) begin
          out_stall_i <= 1'b1;
          repeat (g) @(negedge clk_i);
          out_stall_i <= 1'b0;
        end else if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(5, 30)) @(negedge clk_i);
        end
      end
    end
  end

  task automatic send(logic [1:0] op, logic [7:0] b);
    ubx_pkg::in_t it;
    int g;
    it.opcode = op;
    it.rx_byte = b;
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(it);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (sb.expected_q.size() > 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic apply_cfg(logic [15:0] drx, logic [15:0] dtx, logic [7:0] glim,
                           logic aen, logic [7:0] alim);
    logic [15:0] v[5];
    drain();
    v = '{drx, dtx, {8'h00, glim}, {15'h0, aen}, {8'h00, alim}};
    for (int i = 0; i < 5; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= 3'(i);
      cfg_data_i <= v[i];
      sb.set_reg(3'(i), v[i]);
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // bad_pos 1..3 breaks that header byte; bad_ck flips a TIMEUTC checksum bit
  task automatic send_frame(logic [7:0] id, bit bad_ck, int bad_pos, int validity);
    logic [7:0] f[$];
    logic [15:0] ck;
    int len, stop;
    len = (id == ubx_pkg::ID_POSLLH) ? ubx_pkg::LEN_POSLLH :
          (id == ubx_pkg::ID_TIMEGPS) ? ubx_pkg::LEN_TIMEGPS : ubx_pkg::LEN_TIMEUTC;
    f = '{ubx_pkg::SYNC1, ubx_pkg::SYNC2, ubx_pkg::CLS_NAV, id};
    for (int i = 4; i < len; i++) f.push_back(8'($urandom));
    if (id == ubx_pkg::ID_TIMEUTC) begin
      if (validity >= 0) f[25][2:0] = 3'(validity);
      ck = nav_scoreboard::fletcher(f[2:25]);
      f[26] = ck[15:8];
      f[27] = ck[7:0];
      if (bad_ck) f[$urandom_range(26, 27)] ^= 8'(1 << $urandom_range(0, 7));
    end
    stop = len;
    if (bad_pos == 1) f[1] = ubx_pkg::SYNC2 ^ 8'(1 << $urandom_range(0, 7));
    if (bad_pos == 2) f[2] = ubx_pkg::CLS_NAV ^ 8'(1 << $urandom_range(0, 7));
    if (bad_pos == 3)
      do f[3] = 8'($urandom);
      while (f[3] == ubx_pkg::ID_POSLLH || f[3] == ubx_pkg::ID_TIMEGPS ||
             f[3] == ubx_pkg::ID_TIMEUTC);
    if (bad_pos > 0) stop = bad_pos + 1 + $urandom_range(0, 4);
    for (int i = 0; i < stop; i++) send(ubx_pkg::OP_RX_BYTE, f[i]);
  endtask

  task automatic poll_and_reply(logic [7:0] id, bit bad_ck, int bad_pos, int validity,
                                bit ack);
    repeat ($urandom_range(1, 4)) send(ubx_pkg::OP_TICK, 8'($urandom));
    send_frame(id, bad_ck, bad_pos, validity);
    if (ack) send(ubx_pkg::OP_STORED, 8'($urandom));
  endtask

  function logic [7:0] pick_id();
    case ($urandom_range(0, 3))
      0: return ubx_pkg::ID_POSLLH;
      1: return ubx_pkg::ID_TIMEGPS;
      default: return ubx_pkg::ID_TIMEUTC;
    endcase
  endfunction

  initial begin
    int r, phase_start;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: poll every tick, all frame types, header faults, odd opcodes
    apply_cfg(16'd0, 16'd0, 8'd255, 1'b0, 8'd255);
    send(OP_UNKNOWN, 8'hB5);
    send(ubx_pkg::OP_TICK, 8'h00);
    send_frame(ubx_pkg::ID_TIMEUTC, 0, 0, 7);
    send(ubx_pkg::OP_RX_BYTE, ubx_pkg::SYNC1);   // store pending, must be ignored
    send(ubx_pkg::OP_STORED, 8'hFF);
    poll_and_reply(ubx_pkg::ID_POSLLH, 0, 1, -1, 1);
    poll_and_reply(ubx_pkg::ID_TIMEGPS, 0, 2, -1, 1);
    poll_and_reply(ubx_pkg::ID_TIMEGPS, 0, 3, -1, 1);
    poll_and_reply(ubx_pkg::ID_TIMEGPS, 0, 0, -1, 1);
    poll_and_reply(ubx_pkg::ID_POSLLH, 0, 0, -1, 1);
    poll_and_reply(ubx_pkg::ID_TIMEUTC, 1, 0, 7, 1);
    poll_and_reply(ubx_pkg::ID_TIMEUTC, 0, 0, 2, 1);

    // minimum limits switch to position polling at once
    apply_cfg(16'd2, 16'd3, 8'd0, 1'b1, 8'd0);
    poll_and_reply(ubx_pkg::ID_TIMEUTC, 0, 0, 3, 1);
    poll_and_reply(ubx_pkg::ID_TIMEUTC, 0, 0, 0, 1);

    // maximum delays: no poll over a short run of ticks, so a start byte is ignored
    apply_cfg(16'hFFFF, 16'hFFFF, 8'd255, 1'b1, 8'd255);
    repeat (8) send(ubx_pkg::OP_TICK, 8'($urandom));
    send(ubx_pkg::OP_RX_BYTE, ubx_pkg::SYNC1);
    send(ubx_pkg::OP_STORED, 8'h00);

    // random phases with fresh settings
    for (int phase = 0; phase < 2; phase++) begin
      apply_cfg(16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
                8'($urandom_range(0, 4)), 1'($urandom), 8'($urandom_range(0, 6)));
      phase_start = items_sent;
      if (phase == 1) hold_req = 1;
      while (items_sent - phase_start < 15) begin
        r = $urandom_range(0, 9);
        if (r < 7)
          poll_and_reply(pick_id(), $urandom_range(0, 5) == 0, 0,
                         $urandom_range(0, 7), $urandom_range(0, 4) != 0);
        else if (r == 7)
          poll_and_reply(pick_id(), 0, $urandom_range(1, 3), -1, 1);
        else if (r == 8)
          repeat ($urandom_range(1, 5)) send(2'($urandom), 8'($urandom));
        else
          send_frame(pick_id(), 0, 0, $urandom_range(0, 7));
        if (phase == 0 && $urandom_range(0, 3) == 0) drain();
      end
    end

    in_valid_i <= 1'b0;
    r = 0;
    while (sb.expected_q.size() > 0 && r < 5000) begin
      @(negedge clk_i);
      r++;
    end
    if (sb.expected_q.size() > 0) begin
      $display("%0t: timeout, %0d results still expected", $realtime, sb.expected_q.size());
      $display("CHECKS FAILED");
      $finish;
    end else begin
      repeat (DRAIN_CYCLES) @(negedge clk_i);
      $display("Covered %0d input transfers: %0d polls, %0d received frames, %0d results.",
               items_sent, sb.polls, sb.frames, sb.checked);
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
        $display("ALL CHECKS PASSED");
      end else begin
        $display("CHECKS FAILED");
      end
      $finish;
    end
  end
endmodule
